>>> hdl/bridge_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Bridge frame receiver assertion macros
// Concurrent assertion wrappers for the receiver. Defining NO_ASSERTIONS
// turns every use into empty text.
// ----------------------------------------------------------------------------
`ifndef BRIDGE_FRAME_RECEIVER_ASSERT_SVH
`define BRIDGE_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bridge frame receiver: implication check failed");

`define BFR_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bridge frame receiver: forbidden condition seen");

`else

`define BFR_ASSERT_IMP(label, clk, rst, ante, cons)

`define BFR_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> hdl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// Bridge frame receiver package
// Item types, register indexes, result codes and defaults shared by the
// receiver modules.
// ----------------------------------------------------------------------------
package bfr_pkg;

   localparam int LEN_W = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int CHANNEL_FRAME_BYTES_DEF = 22;
   localparam int COMMAND_PAYLOAD_BYTES_DEF = 24;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_TYPE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_BASE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_MASK = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERIAL_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TIMEOUT = 3'd6;

   localparam logic [7:0] SYNC_FIRST_RST = 8'd79;
   localparam logic [7:0] SYNC_SECOND_RST = 8'd87;
   localparam logic [7:0] CHANNEL_TYPE_RST = 8'd255;
   localparam logic [7:0] COMMAND_BASE_RST = 8'd160;
   localparam logic [7:0] COMMAND_MASK_RST = 8'd224;
   localparam logic [LEN_W-1:0] SERIAL_LIMIT_RST = 6'd24;
   localparam logic [15:0] GAP_TIMEOUT_RST = 16'd250;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] PKIND_SERIAL = 2'd0;
   localparam logic [1:0] PKIND_CHANNEL = 2'd1;
   localparam logic [1:0] PKIND_COMMAND = 2'd2;

   localparam logic [1:0] FKIND_EMPTY = 2'd0;
   localparam logic [1:0] FKIND_SERIAL = 2'd1;
   localparam logic [1:0] FKIND_CHANNEL = 2'd2;
   localparam logic [1:0] FKIND_COMMAND = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_GAP = 2'd1;
   localparam logic [1:0] ERR_BAD_SYNC = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG = 2'd3;

   typedef struct packed {
      logic        op;
      logic [7:0]  rx_byte;
      logic [15:0] time_us;
   } bfr_req_type;

   typedef struct packed {
      logic             payload_valid;
      logic [1:0]       payload_kind;
      logic [LEN_W-1:0] payload_index;
      logic [7:0]       payload_byte;
      logic             frame_done;
      logic [1:0]       frame_kind;
      logic [1:0]       error_code;
   } bfr_rsp_type;

   typedef struct packed {
      logic       release_op;
      logic       gap_over;
      logic       is_sync_first;
      logic       is_sync_second;
      logic       is_channel;
      logic       is_command;
      logic       too_long;
      logic       is_zero;
      logic [7:0] rx_byte;
      logic [7:0] command_id;
   } bfr_class_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bfr_qstat_type;

endpackage

>>> hdl/bfr_front.sv
// ----------------------------------------------------------------------------
// Bridge frame receiver front end
// Holds the configuration registers and the last byte timestamp, and
// classifies each accepted item against the configuration.
// ----------------------------------------------------------------------------
module bfr_front import bfr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bfr_req_type            req_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output bfr_class_type          item_class
);

   logic [7:0]       sync_first_ff;
   logic [7:0]       sync_second_ff;
   logic [7:0]       channel_type_ff;
   logic [7:0]       command_base_ff;
   logic [7:0]       command_mask_ff;
   logic [LEN_W-1:0] serial_limit_ff;
   logic [15:0]      gap_timeout_ff;
   logic [15:0]      last_time_ff;
   logic [15:0]      last_time_in;
   logic [15:0]      gap;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         channel_type_ff <= CHANNEL_TYPE_RST;
         command_base_ff <= COMMAND_BASE_RST;
         command_mask_ff <= COMMAND_MASK_RST;
         serial_limit_ff <= SERIAL_LIMIT_RST;
         gap_timeout_ff <= GAP_TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_FIRST: begin
               sync_first_ff <= csr_wdata[7:0];
            end
            CSR_SYNC_SECOND: begin
               sync_second_ff <= csr_wdata[7:0];
            end
            CSR_CHANNEL_TYPE: begin
               channel_type_ff <= csr_wdata[7:0];
            end
            CSR_COMMAND_BASE: begin
               command_base_ff <= csr_wdata[7:0];
            end
            CSR_COMMAND_MASK: begin
               command_mask_ff <= csr_wdata[7:0];
            end
            CSR_SERIAL_LIMIT: begin
               serial_limit_ff <= csr_wdata[LEN_W-1:0];
            end
            CSR_GAP_TIMEOUT: begin
               gap_timeout_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Every received byte refreshes the timestamp, whatever the receiver state.
   always_comb begin
      last_time_in = last_time_ff;
      if (push && req_data.op == OP_BYTE) begin
         last_time_in = req_data.time_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
      end else begin
         last_time_ff <= last_time_in;
      end
   end

   always_comb begin
      gap = req_data.time_us - last_time_ff;
      item_class.release_op = (req_data.op == OP_RELEASE);
      item_class.gap_over = (gap > gap_timeout_ff);
      item_class.is_sync_first = (req_data.rx_byte == sync_first_ff);
      item_class.is_sync_second = (req_data.rx_byte == sync_second_ff);
      item_class.is_channel = (req_data.rx_byte == channel_type_ff);
      item_class.is_command = (req_data.rx_byte >= command_base_ff);
      item_class.too_long = (req_data.rx_byte > {2'b00, serial_limit_ff});
      item_class.is_zero = (req_data.rx_byte == 8'd0);
      item_class.rx_byte = req_data.rx_byte;
      item_class.command_id = req_data.rx_byte & ~command_mask_ff;
   end

endmodule

>>> hdl/bfr_queue.sv
// ----------------------------------------------------------------------------
// Bridge frame receiver item queue
// Short first-in first-out queue of classified items between the front end
// and the frame state machine.
// ----------------------------------------------------------------------------
module bfr_queue import bfr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  bfr_class_type push_data,
   input  logic          pop,
   output bfr_class_type head_data,
   output bfr_qstat_type qstat
);

   localparam int PTR_W = (QUEUE_DEPTH_DEF > 1) ? $clog2(QUEUE_DEPTH_DEF) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH_DEF + 1);

   bfr_class_type    entry_ff [QUEUE_DEPTH_DEF];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH_DEF - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH_DEF - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = entry_ff[rd_ptr_ff];
   assign qstat.full = (count_ff == CNT_W'(QUEUE_DEPTH_DEF));
   assign qstat.empty = (count_ff == '0);

endmodule

>>> hdl/bfr_back.sv
// ----------------------------------------------------------------------------
// Bridge frame receiver frame engine
// Frame state machine that consumes classified items one per cycle while the
// output register is free or drained, and writes one result per item into it.
// ----------------------------------------------------------------------------
module bfr_back import bfr_pkg::*; #(
   parameter int CHANNEL_FRAME_BYTES = CHANNEL_FRAME_BYTES_DEF,
   parameter int COMMAND_PAYLOAD_BYTES = COMMAND_PAYLOAD_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  bfr_class_type head_data,
   input  logic          head_valid,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output bfr_rsp_type   rsp_data
);

   localparam logic [LEN_W-1:0] ChannelLen = LEN_W'(CHANNEL_FRAME_BYTES);
   localparam logic [LEN_W-1:0] CommandLen = LEN_W'(COMMAND_PAYLOAD_BYTES);

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_SYNC2   = 7'b0000010,
      PH_TYPE    = 7'b0000100,
      PH_SERIAL  = 7'b0001000,
      PH_CHANNEL = 7'b0010000,
      PH_COMMAND = 7'b0100000,
      PH_WAIT    = 7'b1000000
   } bfr_phase_type;

   bfr_phase_type    phase_ff;
   bfr_phase_type    phase_in;
   bfr_phase_type    phase_eff;
   logic [LEN_W-1:0] count_ff;
   logic [LEN_W-1:0] count_in;
   logic [LEN_W-1:0] count_inc;
   logic [LEN_W-1:0] length_ff;
   logic [LEN_W-1:0] length_in;
   logic             rsp_valid_ff;
   bfr_rsp_type      rsp_data_ff;
   bfr_rsp_type      result;

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      phase_eff = phase_ff;
      count_in = count_ff;
      length_in = length_ff;
      result = '0;
      if (head_data.release_op) begin
         if (phase_ff == PH_WAIT) begin
            phase_in = PH_IDLE;
         end
      end else begin
         if (phase_ff != PH_IDLE && head_data.gap_over) begin
            phase_eff = PH_IDLE;
            result.error_code = ERR_GAP;
         end
         phase_in = phase_eff;
         case (phase_eff)
            PH_IDLE: begin
               phase_in = head_data.is_sync_first ? PH_SYNC2 : PH_IDLE;
            end
            PH_SYNC2: begin
               if (head_data.is_sync_second) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in = PH_IDLE;
                  result.error_code = ERR_BAD_SYNC;
               end
            end
            PH_TYPE: begin
               count_in = '0;
               if (head_data.is_channel) begin
                  length_in = ChannelLen;
                  phase_in = PH_CHANNEL;
               end else if (head_data.is_command) begin
                  result.payload_valid = 1'b1;
                  result.payload_kind = PKIND_COMMAND;
                  result.payload_byte = head_data.command_id;
                  count_in = LEN_W'(1);
                  length_in = CommandLen;
                  phase_in = PH_COMMAND;
               end else if (head_data.too_long) begin
                  phase_in = PH_IDLE;
                  result.error_code = ERR_TOO_LONG;
               end else if (!head_data.is_zero) begin
                  length_in = head_data.rx_byte[LEN_W-1:0];
                  phase_in = PH_SERIAL;
               end else begin
                  result.frame_done = 1'b1;
                  result.frame_kind = FKIND_EMPTY;
                  phase_in = PH_WAIT;
               end
            end
            PH_SERIAL: begin
               result.payload_valid = 1'b1;
               result.payload_kind = PKIND_SERIAL;
               result.payload_index = count_ff;
               result.payload_byte = head_data.rx_byte;
               count_in = count_inc;
               if (count_inc >= length_ff) begin
                  result.frame_done = 1'b1;
                  result.frame_kind = FKIND_SERIAL;
                  phase_in = PH_WAIT;
               end
            end
            PH_CHANNEL: begin
               result.payload_valid = 1'b1;
               result.payload_kind = PKIND_CHANNEL;
               result.payload_index = count_ff;
               result.payload_byte = head_data.rx_byte;
               count_in = count_inc;
               if (count_inc >= length_ff) begin
                  result.frame_done = 1'b1;
                  result.frame_kind = FKIND_CHANNEL;
                  phase_in = PH_WAIT;
               end
            end
            PH_COMMAND: begin
               result.payload_valid = 1'b1;
               result.payload_kind = PKIND_COMMAND;
               result.payload_index = count_ff;
               result.payload_byte = head_data.rx_byte;
               count_in = count_inc;
               // The command id took index 0, so the payload ends one byte later.
               if (count_inc > length_ff) begin
                  result.frame_done = 1'b1;
                  result.frame_kind = FKIND_COMMAND;
                  phase_in = PH_WAIT;
               end
            end
            PH_WAIT: begin
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         length_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         length_ff <= length_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> hdl/bridge_frame_receiver.sv
// ----------------------------------------------------------------------------
// Bridge frame receiver
// Finds sync bytes, decodes the type/length byte and streams frame payload
// bytes with their kind and index, one result per item.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the req_ channel: a received byte with its microsecond
// timestamp, or a release that ends the wait after a frame. Each item gives
// exactly one result on the rsp_ channel, in order.
// Configuration is written through csr_we, csr_index and csr_wdata while no
// item is in flight; writes take effect at the next clock edge.
// An accepted item is first written into the queue; its result is then loaded
// from the queue head into the output register once that register is free.
// Throughput is one item per cycle while the output register is free or being
// drained, with the frame state register updated for each item taken.
// A two-entry queue sits between the classifier and the frame state machine.
// When rsp_ready is low the output register holds its result, the queue fills
// and req_ready drops once it is full; nothing is lost.
// Reset restores the register defaults, empties the queue, clears the output
// register valid flag and puts the receiver back to hunting the first sync byte.
// ----------------------------------------------------------------------------
`include "bridge_frame_receiver_assert.svh"

module bridge_frame_receiver import bfr_pkg::*; #(
   parameter int CHANNEL_FRAME_BYTES = CHANNEL_FRAME_BYTES_DEF,
   parameter int COMMAND_PAYLOAD_BYTES = COMMAND_PAYLOAD_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bfr_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bfr_rsp_type            rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic          push;
   logic          pop;
   bfr_class_type item_class;
   bfr_class_type head_data;
   bfr_qstat_type qstat;
   logic          rsp_done;
   logic          rsp_no_payload;
   logic          payload_clear;

   assign req_ready = !qstat.full;
   assign push = req_valid && req_ready;

   bfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_class (item_class)
   );

   bfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (item_class),
      .pop       (pop),
      .head_data (head_data),
      .qstat     (qstat)
   );

   bfr_back #(
      .CHANNEL_FRAME_BYTES   (CHANNEL_FRAME_BYTES),
      .COMMAND_PAYLOAD_BYTES (COMMAND_PAYLOAD_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .head_valid (!qstat.empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_done = rsp_valid && rsp_data.frame_done;
   assign rsp_no_payload = rsp_valid && !rsp_data.payload_valid;
   assign payload_clear = (rsp_data.payload_index == '0) && (rsp_data.payload_byte == '0)
                          && (rsp_data.payload_kind == '0);

   `BFR_ASSERT_NEVER(a_queue_status, clock, reset, qstat.full && qstat.empty)
   `BFR_ASSERT_IMP(a_done_no_error, clock, reset, rsp_done, rsp_data.error_code == ERR_NONE)
   `BFR_ASSERT_IMP(a_idle_payload, clock, reset, rsp_no_payload, payload_clear)

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bridge frame receiver testbench
// Drives received bytes and release items into the receiver and checks every
// result, field by field, against a cycle-free frame decoder kept in step
// with the accepted items, or against the result given in a table row. A short
// table of hand-picked items comes first, then random well-formed frames mixed
// with broken frames and noise under several register settings, with random idling and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
   import bfr_pkg::*;

   typedef enum logic [2:0] {
      RX_HUNT, RX_SYNC2, RX_TYPE, RX_SERIAL, RX_CHANNEL, RX_COMMAND, RX_WAIT
   } rx_phase_type;

   typedef struct packed {
      logic [7:0]       sync_a;
      logic [7:0]       sync_b;
      logic [7:0]       chan;
      logic [7:0]       cmd_base;
      logic [7:0]       cmd_mask;
      logic [LEN_W-1:0] ser_limit;
      logic [15:0]      gap;
   } rx_cfg_type;

   typedef struct {
      bfr_req_type item;
      bit          typed;
      bfr_rsp_type want;
   } dir_row_type;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 150;
   localparam int NUM_PHASES = 8;
   localparam rx_cfg_type CFG_DEFAULT = '{SYNC_FIRST_RST, SYNC_SECOND_RST, CHANNEL_TYPE_RST,
      COMMAND_BASE_RST, COMMAND_MASK_RST, SERIAL_LIMIT_RST, GAP_TIMEOUT_RST};
   localparam bfr_rsp_type RSP_QUIET = '0;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bfr_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bfr_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit dir_typed = 1'b0;
   bfr_rsp_type dir_want = '0;
   bit steady_src = 1'b0;
   bit steady_sink = 1'b0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   rx_cfg_type drive_cfg = CFG_DEFAULT;
   logic [15:0] now_us = '0;
   int items_sent = 0;
   int config_count = 0;

   rx_cfg_type pred_cfg;
   rx_phase_type rx_phase;
   logic [LEN_W-1:0] rx_count;
   logic [LEN_W-1:0] rx_length;
   logic [15:0] rx_last_us;
   bfr_rsp_type awaited_q[$];
   int fault_count = 0;
   int results_seen = 0;
   int quiet_cycles = 0;
   int done_by_kind[4] = '{0, 0, 0, 0};
   int err_by_code[4] = '{0, 0, 0, 0};

   dir_row_type dir_rows[22] = '{
      '{'{OP_RELEASE, 8'hFF, 16'hFFFF}, 1'b1, RSP_QUIET},
      '{'{OP_BYTE, 8'h4F, 16'd10}, 1'b1, RSP_QUIET},
      '{'{OP_BYTE, 8'h00, 16'd20}, 1'b1, '{error_code: ERR_BAD_SYNC, default: '0}},
      '{'{OP_BYTE, 8'h4F, 16'd30}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h57, 16'd40}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'd25, 16'd50}, 1'b1, '{error_code: ERR_TOO_LONG, default: '0}},
      '{'{OP_BYTE, 8'h4F, 16'd60}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h57, 16'd70}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h00, 16'd80}, 1'b1,
         '{frame_done: 1'b1, frame_kind: FKIND_EMPTY, default: '0}},
      '{'{OP_BYTE, 8'h4F, 16'd90}, 1'b0, RSP_QUIET},
      '{'{OP_RELEASE, 8'h00, 16'd0}, 1'b1, RSP_QUIET},
      '{'{OP_BYTE, 8'h4F, 16'd100}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h57, 16'd110}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h01, 16'd120}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'hFF, 16'd130}, 1'b1,
         '{payload_valid: 1'b1, payload_kind: PKIND_SERIAL, payload_index: 6'd0,
           payload_byte: 8'hFF, frame_done: 1'b1, frame_kind: FKIND_SERIAL,
           error_code: ERR_NONE}},
      '{'{OP_RELEASE, 8'h5A, 16'hA5A5}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h4F, 16'd200}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h57, 16'd451}, 1'b1, '{error_code: ERR_GAP, default: '0}},
      '{'{OP_BYTE, 8'h4F, 16'hFFF0}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h57, 16'h0010}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'hE7, 16'h0020}, 1'b0, RSP_QUIET},
      '{'{OP_BYTE, 8'h00, 16'h0030}, 1'b0, RSP_QUIET}
   };

   bridge_frame_receiver dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bfr_rsp_type next_frame_result(input bfr_req_type item);
      bfr_rsp_type res;
      logic [15:0] gap;
      logic fin;
      logic [1:0] fkind;
      res = '0;
      if (item.op == OP_RELEASE) begin
         if (rx_phase == RX_WAIT) rx_phase = RX_HUNT;
         return res;
      end
      if (rx_phase != RX_HUNT) begin
         gap = item.time_us - rx_last_us;
         if (gap > pred_cfg.gap) begin
            rx_phase = RX_HUNT;
            res.error_code = ERR_GAP;
         end
      end
      rx_last_us = item.time_us;
      case (rx_phase)
         RX_SYNC2: begin
            if (item.rx_byte == pred_cfg.sync_b) begin
               rx_phase = RX_TYPE;
            end else begin
               rx_phase = RX_HUNT;
               res.error_code = ERR_BAD_SYNC;
            end
         end
         RX_TYPE: begin
            rx_count = '0;
            if (item.rx_byte == pred_cfg.chan) begin
               rx_length = LEN_W'(CHANNEL_FRAME_BYTES_DEF);
               rx_phase = RX_CHANNEL;
            end else if (item.rx_byte >= pred_cfg.cmd_base) begin
               res.payload_valid = 1'b1;
               res.payload_kind = PKIND_COMMAND;
               res.payload_byte = item.rx_byte & ~pred_cfg.cmd_mask;
               rx_count = LEN_W'(1);
               rx_length = LEN_W'(COMMAND_PAYLOAD_BYTES_DEF);
               rx_phase = RX_COMMAND;
            end else if (item.rx_byte > pred_cfg.ser_limit) begin
               rx_phase = RX_HUNT;
               res.error_code = ERR_TOO_LONG;
            end else if (item.rx_byte != 8'd0) begin
               rx_length = item.rx_byte[LEN_W-1:0];
               rx_phase = RX_SERIAL;
            end else begin
               res.frame_done = 1'b1;
               res.frame_kind = FKIND_EMPTY;
               rx_phase = RX_WAIT;
            end
         end
         RX_SERIAL, RX_CHANNEL, RX_COMMAND: begin
            res.payload_valid = 1'b1;
            res.payload_index = rx_count;
            res.payload_byte = item.rx_byte;
            rx_count = rx_count + LEN_W'(1);
            if (rx_phase == RX_SERIAL) begin
               res.payload_kind = PKIND_SERIAL;
               fkind = FKIND_SERIAL;
               fin = rx_count >= rx_length;
            end else if (rx_phase == RX_CHANNEL) begin
               res.payload_kind = PKIND_CHANNEL;
               fkind = FKIND_CHANNEL;
               fin = rx_count >= rx_length;
            end else begin
               res.payload_kind = PKIND_COMMAND;
               fkind = FKIND_COMMAND;
               fin = {1'b0, rx_count} >= {1'b0, rx_length} + 7'd1;
            end
            if (fin) begin
               res.frame_done = 1'b1;
               res.frame_kind = fkind;
               rx_phase = RX_WAIT;
            end
         end
         RX_WAIT: begin
         end
         default: begin
            if (item.rx_byte == pred_cfg.sync_a) rx_phase = RX_SYNC2;
            else rx_phase = RX_HUNT;
         end
      endcase
      return res;
   endfunction

   task automatic check_field(input string fname, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", fname, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      bfr_rsp_type want;
      if (reset) begin
         pred_cfg = CFG_DEFAULT;
         rx_phase = RX_HUNT;
         rx_count = '0;
         rx_length = '0;
         rx_last_us = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SYNC_FIRST: pred_cfg.sync_a = csr_wdata[7:0];
               CSR_SYNC_SECOND: pred_cfg.sync_b = csr_wdata[7:0];
               CSR_CHANNEL_TYPE: pred_cfg.chan = csr_wdata[7:0];
               CSR_COMMAND_BASE: pred_cfg.cmd_base = csr_wdata[7:0];
               CSR_COMMAND_MASK: pred_cfg.cmd_mask = csr_wdata[7:0];
               CSR_SERIAL_LIMIT: pred_cfg.ser_limit = csr_wdata[LEN_W-1:0];
               CSR_GAP_TIMEOUT: pred_cfg.gap = csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            want = next_frame_result(req_data);
            if (dir_typed) want = dir_want;
            awaited_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_q.size() == 0) begin
               $error("result arrived with no expectation waiting");
               fault_count++;
            end else begin
               want = awaited_q.pop_front();
               check_field("payload_valid", want.payload_valid, rsp_data.payload_valid);
               check_field("payload_kind", want.payload_kind, rsp_data.payload_kind);
               check_field("payload_index", want.payload_index, rsp_data.payload_index);
               check_field("payload_byte", want.payload_byte, rsp_data.payload_byte);
               check_field("frame_done", want.frame_done, rsp_data.frame_done);
               check_field("frame_kind", want.frame_kind, rsp_data.frame_kind);
               check_field("error_code", want.error_code, rsp_data.error_code);
               results_seen++;
               if (want.frame_done) done_by_kind[want.frame_kind]++;
               err_by_code[want.error_code]++;
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= 80;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= steady_sink || ($urandom_range(99) >= 23);
      end
   end

   task automatic offer(input bfr_req_type item, input bit typed, input bfr_rsp_type want);
      while (!steady_src && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      dir_typed <= typed;
      dir_want <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      int unsigned pick;
      logic [15:0] step;
      pick = $urandom_range(999);
      if (pick < 5 && drive_cfg.gap != 16'hFFFF) step = drive_cfg.gap + 16'd1;
      else if (pick < 10) step = 16'($urandom);
      else if (pick < 50) step = drive_cfg.gap;
      else step = 16'($urandom_range(0, drive_cfg.gap));
      now_us = now_us + step;
      offer('{OP_BYTE, b, now_us}, 1'b0, RSP_QUIET);
   endtask

   task automatic send_frame();
      int kind_pick;
      int n;
      logic [7:0] type_byte;
      kind_pick = $urandom_range(99);
      send_byte(drive_cfg.sync_a);
      if (kind_pick < 5) begin
         send_byte(drive_cfg.sync_b ^ 8'($urandom_range(1, 255)));
         return;
      end
      send_byte(drive_cfg.sync_b);
      n = 0;
      if (kind_pick < 22) begin
         type_byte = drive_cfg.chan;
         n = CHANNEL_FRAME_BYTES_DEF;
      end else if (kind_pick < 40) begin
         type_byte = 8'($urandom_range(drive_cfg.cmd_base, 255));
         n = COMMAND_PAYLOAD_BYTES_DEF;
      end else if (kind_pick < 85) begin
         if ($urandom_range(3) == 0) n = $urandom_range(1, drive_cfg.ser_limit);
         else n = $urandom_range(1, (drive_cfg.ser_limit < 8) ? drive_cfg.ser_limit : 8);
         type_byte = 8'(n);
      end else if (kind_pick < 92) begin
         type_byte = 8'h00;
      end else begin
         type_byte = 8'($urandom_range(drive_cfg.ser_limit + 1, 255));
      end
      send_byte(type_byte);
      if ($urandom_range(9) == 0) n = $urandom_range(0, n);
      repeat (n) send_byte(8'($urandom));
      if ($urandom_range(99) < 85) offer('{OP_RELEASE, 8'($urandom), 16'($urandom)}, 1'b0,
                                         RSP_QUIET);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input rx_cfg_type c);
      logic [CSR_INDEX_W-1:0] idx[7];
      logic [CSR_DATA_W-1:0] val[7];
      idx = '{CSR_SYNC_FIRST, CSR_SYNC_SECOND, CSR_CHANNEL_TYPE, CSR_COMMAND_BASE,
              CSR_COMMAND_MASK, CSR_SERIAL_LIMIT, CSR_GAP_TIMEOUT};
      val = '{{8'($urandom), c.sync_a}, {8'($urandom), c.sync_b}, {8'($urandom), c.chan},
              {8'($urandom), c.cmd_base}, {8'($urandom), c.cmd_mask},
              {10'($urandom), c.ser_limit}, c.gap};
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      drive_cfg = c;
      config_count++;
   endtask

   initial begin : stimulus
      rx_cfg_type c;
      int phase_end;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      now_us = dir_rows[21].item.time_us;

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            0: c = CFG_DEFAULT;
            1: c = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 6'd1, 16'd0};
            2: c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd63, 16'hFFFF};
            default: begin
               c.sync_a = 8'($urandom);
               c.sync_b = 8'($urandom);
               c.chan = 8'($urandom);
               c.cmd_base = 8'($urandom);
               c.cmd_mask = 8'($urandom);
               c.ser_limit = 6'($urandom_range(1, 63));
               if ($urandom_range(3) == 0) c.gap = 16'($urandom);
               else c.gap = 16'($urandom_range(0, 400));
            end
         endcase
         set_config(c);
         steady_src <= (p == 0 || p == 3);
         steady_sink <= (p == 3);
         hold_req <= (p == 0);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(4) == 0)
                     offer('{OP_RELEASE, 8'($urandom), 16'($urandom)}, 1'b0, RSP_QUIET);
                  else
                     send_byte(8'($urandom));
               end
            end
            send_frame();
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (awaited_q.size() != 0) begin
         $error("%0d expected results never arrived", awaited_q.size());
         fault_count++;
      end
      $display("Covered %0d items and %0d results over %0d register settings.",
               items_sent, results_seen, config_count);
      $display("Frames empty/serial/channel/command %0d/%0d/%0d/%0d; errors gap/sync/length %0d/%0d/%0d.",
               done_by_kind[0], done_by_kind[1], done_by_kind[2], done_by_kind[3],
               err_by_code[1], err_by_code[2], err_by_code[3]);
      if (fault_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

>>> bridge_frame_receiver.f
+incdir+hdl
hdl/bfr_pkg.sv
hdl/bfr_front.sv
hdl/bfr_queue.sv
hdl/bfr_back.sv
hdl/bridge_frame_receiver.sv
verif/tb_top.sv
